>>> rtl/edge_hysteresis_3x3_assert.svh
// Assertion macros shared by the edge hysteresis RTL.
`ifndef EDGE_HYSTERESIS_3X3_ASSERT_SVH
`define EDGE_HYSTERESIS_3X3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EHY_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EHY_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/ehy_pkg.sv
// Package with shared types, constants and helpers of the edge hysteresis block.
`default_nettype none
package ehy_pkg;

  localparam int unsigned MaxWidthDefault = 4096;
  localparam int unsigned HeightLimit     = 4096;
  localparam int unsigned PixelW          = 32;
  localparam int unsigned CfgW            = 13;
  localparam int unsigned LevelW          = 8;
  localparam int unsigned RowW            = 12;
  localparam int unsigned CfgDataW        = 13;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [CfgW-1:0]   FrameWidthReset  = 13'd640;
  localparam logic [CfgW-1:0]   FrameHeightReset = 13'd480;
  localparam logic [LevelW-1:0] WeakLevelReset   = 8'd25;
  localparam logic [LevelW-1:0] StrongLevelReset = 8'd255;
  localparam logic [LevelW-1:0] OpaqueAlpha      = 8'hFF;
  localparam logic [PixelW-1:0] BlackPixel       = 32'h0000_00FF;

  typedef enum logic [1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgWeakLevel   = 2'd2,
    CfgStrongLevel = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0]   frame_width;
    logic [CfgW-1:0]   frame_height;
    logic [LevelW-1:0] weak_level;
    logic [LevelW-1:0] strong_level;
  } cfg_t;

  typedef struct packed {
    logic [PixelW-1:0] px0;
    logic [PixelW-1:0] px1;
    logic              two;
  } entry_t;

  function automatic logic rgb_is(logic [PixelW-1:0] px, logic [LevelW-1:0] lvl);
    return (px[31:24] == lvl) && (px[23:16] == lvl) && (px[15:8] == lvl);
  endfunction

endpackage
`default_nettype wire

>>> rtl/ehy_front.sv
// Front end: keeps the column window and counters and classifies each item.
`default_nettype none
module ehy_front #(
  parameter int unsigned MaxWidth = ehy_pkg::MaxWidthDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ehy_pkg::cfg_t              cfg_i,
  input  wire logic                       accept_i,
  input  wire logic [ehy_pkg::PixelW-1:0] above_i,
  input  wire logic [ehy_pkg::PixelW-1:0] center_i,
  input  wire logic [ehy_pkg::PixelW-1:0] below_i,
  output logic                            wr_o,
  output ehy_pkg::entry_t                 entry_o
);

  localparam int unsigned CmpW = ($clog2(MaxWidth + 1) > ehy_pkg::CfgW) ?
                                 $clog2(MaxWidth + 1) : ehy_pkg::CfgW;
  localparam int unsigned ColW = $clog2(MaxWidth);

  logic [ColW-1:0]                    col_q, col_d;
  logic [ehy_pkg::RowW-1:0]           row_q, row_d;
  logic [2:0][ehy_pkg::PixelW-1:0]    older_q, newer_q;
  logic [CmpW-1:0]                    fw_ext, wm1;
  logic [ehy_pkg::RowW-1:0]           hm1;
  logic                               last_col, border_row, have_left, left_border;
  logic                               hit;
  logic [ehy_pkg::LevelW-1:0]         s;
  logic [ehy_pkg::PixelW-1:0]         dec_px;

  always_comb begin
    fw_ext = CmpW'(cfg_i.frame_width);
    if (fw_ext == '0) begin
      wm1 = '0;
    end else if (fw_ext > CmpW'(MaxWidth)) begin
      wm1 = CmpW'(MaxWidth - 1);
    end else begin
      wm1 = fw_ext - CmpW'(1);
    end
    if (cfg_i.frame_height == '0) begin
      hm1 = '0;
    end else if (cfg_i.frame_height > ehy_pkg::CfgW'(ehy_pkg::HeightLimit)) begin
      hm1 = ehy_pkg::RowW'(ehy_pkg::HeightLimit - 1);
    end else begin
      hm1 = ehy_pkg::RowW'(cfg_i.frame_height - ehy_pkg::CfgW'(1));
    end
  end

  assign last_col    = CmpW'(col_q) >= wm1;
  assign border_row  = (row_q == '0) || (row_q >= hm1);
  assign have_left   = col_q != '0;
  assign left_border = border_row || (col_q == ColW'(1));
  assign s           = cfg_i.strong_level;

  assign hit = ehy_pkg::rgb_is(older_q[0], s) || ehy_pkg::rgb_is(older_q[1], s) ||
               ehy_pkg::rgb_is(older_q[2], s) || ehy_pkg::rgb_is(newer_q[0], s) ||
               ehy_pkg::rgb_is(newer_q[2], s) || ehy_pkg::rgb_is(above_i, s) ||
               ehy_pkg::rgb_is(center_i, s) || ehy_pkg::rgb_is(below_i, s);

  always_comb begin
    dec_px = newer_q[1];
    if (!left_border && ehy_pkg::rgb_is(newer_q[1], cfg_i.weak_level)) begin
      dec_px = hit ? {s, s, s, ehy_pkg::OpaqueAlpha} : ehy_pkg::BlackPixel;
    end
    if (have_left) begin
      entry_o.px0 = dec_px;
      entry_o.px1 = center_i;
      entry_o.two = last_col;
    end else begin
      entry_o.px0 = center_i;
      entry_o.px1 = center_i;
      entry_o.two = 1'b0;
    end
  end

  assign wr_o = accept_i && (have_left || last_col);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_q >= hm1) ? '0 : row_q + ehy_pkg::RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      older_q <= newer_q;
      newer_q <= {below_i, center_i, above_i};
    end
  end

endmodule
`default_nettype wire

>>> rtl/ehy_queue.sv
// Short queue of classified entries between the front and back ends.
`default_nettype none
`include "edge_hysteresis_3x3_assert.svh"
module ehy_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire ehy_pkg::entry_t wr_entry_i,
  input  wire logic            rd_i,
  output ehy_pkg::entry_t      rd_entry_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned Depth = ehy_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ehy_pkg::entry_t     mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o     = cnt_q == CntW'(Depth);
  assign empty_o    = cnt_q == '0;
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  `EHY_ASSERT_SAME(a_no_write_when_full, clk_i, rst_ni, wr_i, !full_o)
  `EHY_ASSERT_SAME(a_no_read_when_empty, clk_i, rst_ni, rd_i, !empty_o)

endmodule
`default_nettype wire

>>> rtl/ehy_back.sv
// Back end: expands queue entries into result items in the output register.
`default_nettype none
`include "edge_hysteresis_3x3_assert.svh"
module ehy_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ehy_pkg::entry_t            entry_i,
  input  wire logic                       q_empty_i,
  output logic                            q_rd_o,
  input  wire logic                       pop_i,
  output logic                            empty_o,
  output logic [ehy_pkg::PixelW-1:0]      out_pixel_o,
  output logic                            last_of_item_o
);

  logic                        out_valid_q, out_valid_d;
  logic [ehy_pkg::PixelW-1:0]  out_px_q, out_px_d;
  logic                        out_last_q, out_last_d;
  logic                        pend_q, pend_d;
  logic [ehy_pkg::PixelW-1:0]  pend_px_q, pend_px_d;
  logic                        load;

  assign load = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_px_d    = out_px_q;
    out_last_d  = out_last_q;
    pend_d      = pend_q;
    pend_px_d   = pend_px_q;
    q_rd_o      = 1'b0;
    if (load) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_px_d    = pend_px_q;
        out_last_d  = 1'b1;
        pend_d      = 1'b0;
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        out_px_d    = entry_i.px0;
        out_last_d  = !entry_i.two;
        pend_d      = entry_i.two;
        pend_px_d   = entry_i.px1;
        q_rd_o      = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_px_q   <= out_px_d;
    out_last_q <= out_last_d;
    pend_px_q  <= pend_px_d;
  end

  assign empty_o        = !out_valid_q;
  assign out_pixel_o    = out_px_q;
  assign last_of_item_o = out_last_q;

  `EHY_ASSERT_SAME(a_pending_needs_shown, clk_i, rst_ni, pend_q, out_valid_q && !out_last_q)
  `EHY_ASSERT_NEXT(a_pair_sets_pending, clk_i, rst_ni, q_rd_o && entry_i.two, pend_q)

endmodule
`default_nettype wire

>>> rtl/edge_hysteresis_3x3.sv
// Top level of the single-pass 8-neighbour edge hysteresis block.
//
// Items are three-pixel columns (above, center, below) in raster order of the
// center pixel, pushed with push while full is low. Results leave as a queue:
// while empty is low the oldest result is on out_pixel_o and last_of_item_o,
// and pop takes it. The first column of a row gives no result unless it is
// the last, each later column gives the pixel to its left, and the last
// column also gives its own center pixel. Registers are written through the
// cfg channel, which is always ready; the user must write them only while the
// block is idle (not enforced by the block). The block accepts one item per
// cycle while full is low; its first result goes through the queue to the
// output register. The output is one result per cycle while pop is high, so
// a row end, with its two results, is absorbed by the four-entry queue
// between the front and back ends. When the receiver stalls, the queue fills
// and full rises. Reset clears the counters, the queue and the output
// register and loads the register reset values; no clearing pass is needed.
`default_nettype none
module edge_hysteresis_3x3 #(
  parameter int unsigned MaxWidth = ehy_pkg::MaxWidthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [ehy_pkg::PixelW-1:0]   pixel_above_i,
  input  wire logic [ehy_pkg::PixelW-1:0]   pixel_center_i,
  input  wire logic [ehy_pkg::PixelW-1:0]   pixel_below_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [ehy_pkg::PixelW-1:0]        out_pixel_o,
  output logic                              last_of_item_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire ehy_pkg::cfg_idx_e            cfg_index_i,
  input  wire logic [ehy_pkg::CfgDataW-1:0] cfg_data_i
);

  ehy_pkg::cfg_t   cfg_q;
  ehy_pkg::entry_t wr_entry, rd_entry;
  logic            accept, q_full, q_empty, q_wr, q_rd;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= ehy_pkg::FrameWidthReset;
      cfg_q.frame_height <= ehy_pkg::FrameHeightReset;
      cfg_q.weak_level   <= ehy_pkg::WeakLevelReset;
      cfg_q.strong_level <= ehy_pkg::StrongLevelReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ehy_pkg::CfgFrameWidth: begin
          cfg_q.frame_width <= cfg_data_i[ehy_pkg::CfgW-1:0];
        end
        ehy_pkg::CfgFrameHeight: begin
          cfg_q.frame_height <= cfg_data_i[ehy_pkg::CfgW-1:0];
        end
        ehy_pkg::CfgWeakLevel: begin
          cfg_q.weak_level <= cfg_data_i[ehy_pkg::LevelW-1:0];
        end
        ehy_pkg::CfgStrongLevel: begin
          cfg_q.strong_level <= cfg_data_i[ehy_pkg::LevelW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ehy_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .above_i  (pixel_above_i),
    .center_i (pixel_center_i),
    .below_i  (pixel_below_i),
    .wr_o     (q_wr),
    .entry_o  (wr_entry)
  );

  ehy_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (wr_entry),
    .rd_i       (q_rd),
    .rd_entry_o (rd_entry),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  ehy_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (rd_entry),
    .q_empty_i      (q_empty),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_pixel_o    (out_pixel_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
`default_nettype wire
